FILE: rtl/core/ipfpm_pkg.sv
package ipfpm_pkg;

   // table geometry
   localparam int ENTRIES = 4;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int TRIES_W = 4;

   // configuration register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH  = 1'd1;

   // register reset values
   localparam logic [TRIES_W-1:0] RETRY_LIMIT_RESET = 4'd8;
   localparam logic [15:0]        MAX_LENGTH_RESET  = 16'd1500;

   // result codes
   localparam logic [1:0] OUT_COMPLETED = 2'd0;
   localparam logic [1:0] OUT_STORED    = 2'd1;
   localparam logic [1:0] OUT_MISMATCH  = 2'd2;
   localparam logic [1:0] OUT_NOSLOT    = 2'd3;

   typedef struct packed {
      logic [15:0] frag_ident;
      logic [31:0] source_addr;
      logic [12:0] offset_units;
      logic [15:0] data_length;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [15:0] total_length;
      logic [1:0]  slot;
      logic [15:0] partner_offset;
      logic [15:0] partner_length;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;
      logic last;
      logic out_blocked;
   } ctrl_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } ctrl_state_type;

endpackage

FILE: rtl/core/ipfpm_ctrl.sv
module ipfpm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ipfpm_pkg::ctrl_status_type status,
   output ipfpm_pkg::ctrl_cmd_type    cmd
);
   import ipfpm_pkg::*;

   ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit || status.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait until the result register can take the item
            if (!status.out_blocked) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // an accepted item always starts a scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SCAN))
      else $error("accepted item did not start a scan");

   // at most one command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.finish}))
      else $error("overlapping datapath commands");

endmodule

FILE: rtl/core/ipfpm_datapath.sv
module ipfpm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ipfpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ipfpm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  ipfpm_pkg::req_item_type             req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ipfpm_pkg::rsp_item_type             rsp_item,
   input  ipfpm_pkg::ctrl_cmd_type             cmd,
   output ipfpm_pkg::ctrl_status_type          status
);
   import ipfpm_pkg::*;

   // configuration
   logic [TRIES_W-1:0] retry_ff, retry_in;
   logic [15:0]        maxlen_ff, maxlen_in;

   // fragment table
   logic [TRIES_W-1:0] tries_ff  [ENTRIES];
   logic [TRIES_W-1:0] tries_in  [ENTRIES];
   logic [15:0]        ident_ff  [ENTRIES];
   logic [31:0]        source_ff [ENTRIES];
   logic [15:0]        eoff_ff   [ENTRIES];
   logic [15:0]        elen_ff   [ENTRIES];

   // scan state
   req_item_type       cur_ff, cur_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               matched_ff, matched_in;
   logic               have_free_ff, have_free_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [15:0]        peoff_ff, peoff_in;
   logic [15:0]        pelen_ff, pelen_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_ff, rsp_in;

   logic               live;
   logic               hit;
   logic               last;
   logic               store_wr;
   logic [15:0]        cur_oset;
   logic [16:0]        sum_cur;
   logic [16:0]        sum_ent;
   logic [16:0]        sum_len;
   logic               pair_ok;

   // per-entry compare at the scan index
   assign live = (tries_ff[idx_ff] != '0);
   assign hit  = live && (ident_ff[idx_ff] == cur_ff.frag_ident)
                      && (source_ff[idx_ff] == cur_ff.source_addr);
   assign last = (idx_ff == IDX_W'(ENTRIES - 1));

   assign status.hit         = hit;
   assign status.last        = last;
   assign status.out_blocked = rsp_valid_ff && rsp_stall;

   // adjacency and length check against the latched partner
   assign cur_oset = {cur_ff.offset_units, 3'b000};
   assign sum_cur  = {1'b0, cur_oset} + {1'b0, cur_ff.data_length};
   assign sum_ent  = {1'b0, peoff_ff} + {1'b0, pelen_ff};
   assign sum_len  = {1'b0, cur_ff.data_length} + {1'b0, pelen_ff};
   assign pair_ok  = ((sum_cur == {1'b0, peoff_ff}) || (sum_ent == {1'b0, cur_oset}))
                     && (sum_len <= {1'b0, maxlen_ff});

   assign store_wr = cmd.finish && !matched_ff && have_free_ff;

   always_comb begin
      retry_in     = retry_ff;
      maxlen_in    = maxlen_ff;
      tries_in     = tries_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      matched_in   = matched_ff;
      have_free_in = have_free_ff;
      hit_idx_in   = hit_idx_ff;
      free_idx_in  = free_idx_ff;
      peoff_in     = peoff_ff;
      pelen_in     = pelen_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // configuration writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RETRY_LIMIT: retry_in  = csr_wdata[TRIES_W-1:0];
            CSR_MAX_LENGTH:  maxlen_in = csr_wdata[15:0];
            default: begin
               retry_in = retry_ff;
            end
         endcase
      end

      // take a new item
      if (cmd.load) begin
         cur_in       = req_item;
         idx_in       = '0;
         matched_in   = 1'b0;
         have_free_in = 1'b0;
      end

      // one entry per scan cycle
      if (cmd.scan) begin
         if (hit) begin
            matched_in = 1'b1;
            hit_idx_in = idx_ff;
            peoff_in   = eoff_ff[idx_ff];
            pelen_in   = elen_ff[idx_ff];
         end else if (live) begin
            tries_in[idx_ff] = tries_ff[idx_ff] - TRIES_W'(1);
         end else begin
            have_free_in = 1'b1;
            free_idx_in  = idx_ff;
         end
         if (!hit && !last) begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end

      // result delivered
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // decide and load the result register
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (matched_ff) begin
            rsp_in.slot = 2'(hit_idx_ff);
            if (pair_ok) begin
               rsp_in.outcome        = OUT_COMPLETED;
               rsp_in.total_length   = sum_len[15:0];
               rsp_in.partner_offset = peoff_ff;
               rsp_in.partner_length = pelen_ff;
               tries_in[hit_idx_ff]  = '0;
            end else begin
               rsp_in.outcome = OUT_MISMATCH;
            end
         end else if (have_free_ff) begin
            rsp_in.outcome        = OUT_STORED;
            rsp_in.slot           = 2'(free_idx_ff);
            tries_in[free_idx_ff] = retry_ff;
         end else begin
            rsp_in.outcome = OUT_NOSLOT;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff     <= RETRY_LIMIT_RESET;
         maxlen_ff    <= MAX_LENGTH_RESET;
         tries_ff     <= '{default: '0};
         matched_ff   <= 1'b0;
         have_free_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         retry_ff     <= retry_in;
         maxlen_ff    <= maxlen_in;
         tries_ff     <= tries_in;
         matched_ff   <= matched_in;
         have_free_ff <= have_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      peoff_ff    <= peoff_in;
      pelen_ff    <= pelen_in;
      rsp_ff      <= rsp_in;
   end

   // table data, written only when a fragment is stored
   always_ff @(posedge clock) begin
      if (store_wr) begin
         ident_ff[free_idx_ff]  <= cur_ff.frag_ident;
         source_ff[free_idx_ff] <= cur_ff.source_addr;
         eoff_ff[free_idx_ff]   <= cur_oset;
         elen_ff[free_idx_ff]   <= cur_ff.data_length;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // a finished item never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   // a dropped fragment without a slot reports a zero slot and a zero total length
   a_noslot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.outcome == OUT_NOSLOT))
      |-> ((rsp_ff.slot == '0) && (rsp_ff.total_length == '0)))
      else $error("no-slot result carries data");

endmodule

FILE: rtl/core/ip_fragment_pair_matcher.sv
// A result is registered once its item has been scanned: one scan cycle per table entry
// until a match or the last entry, then a decision in the finish state, which waits while
// a result is still stalled. A new item is taken only after the last one is finished,
// as the single compare unit visits one entry per cycle.
// Reset (synchronous): all entries free, retry_limit 8, max_length 1500,
// no result pending; the entry data is not cleared.
module ip_fragment_pair_matcher (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ipfpm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ipfpm_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ipfpm_pkg::req_item_type          req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ipfpm_pkg::rsp_item_type          rsp_item
);
   import ipfpm_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   ipfpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ipfpm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

FILE: bench/ip_fragment_pair_matcher_checker.sv
module ip_fragment_pair_matcher_checker
   import ipfpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_item_type          req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_item_type          rsp_item,
   output int                    mismatch_count,
   output int                    outstanding
);

   // shadow of the fragment table and the registers
   logic [TRIES_W-1:0] tries_q  [ENTRIES];
   logic [15:0]        ident_q  [ENTRIES];
   logic [31:0]        source_q [ENTRIES];
   logic [15:0]        offset_q [ENTRIES];
   logic [15:0]        length_q [ENTRIES];
   logic [TRIES_W-1:0] retry_limit_q;
   logic [15:0]        max_length_q;

   rsp_item_type pending_rsp_q[$];
   int           error_total;

   // scan the table for one fragment header, update it and return the verdict
   function automatic rsp_item_type match_fragment(input req_item_type f);
      rsp_item_type r;
      logic [16:0]  new_off;
      logic [16:0]  new_end;
      logic [16:0]  entry_end;
      logic [16:0]  pair_len;
      logic         found;
      logic         seen_free;
      int           hit;
      int           free_idx;
      int           n;
      r         = '0;
      found     = 1'b0;
      seen_free = 1'b0;
      hit       = 0;
      free_idx  = 0;
      // sums are kept at 17 bits so nothing wraps
      new_off = {1'b0, f.offset_units, 3'b000};
      new_end = new_off + {1'b0, f.data_length};
      for (n = 0; n < ENTRIES && !found; n++) begin
         if (tries_q[n] != '0) begin
            if (ident_q[n] == f.frag_ident && source_q[n] == f.source_addr) begin
               found = 1'b1;
               hit   = n;
            end else begin
               tries_q[n] = tries_q[n] - TRIES_W'(1);
            end
         end else begin
            // last free entry seen wins
            seen_free = 1'b1;
            free_idx  = n;
         end
      end
      if (found) begin
         entry_end = {1'b0, offset_q[hit]} + {1'b0, length_q[hit]};
         pair_len  = {1'b0, f.data_length} + {1'b0, length_q[hit]};
         r.slot    = hit[IDX_W-1:0];
         if ((new_end == {1'b0, offset_q[hit]} || entry_end == new_off) &&
             pair_len <= {1'b0, max_length_q}) begin
            r.outcome        = OUT_COMPLETED;
            r.total_length   = pair_len[15:0];
            r.partner_offset = offset_q[hit];
            r.partner_length = length_q[hit];
            tries_q[hit]     = '0;
         end else begin
            // entry left as it was, tries included
            r.outcome = OUT_MISMATCH;
         end
      end else if (seen_free) begin
         r.outcome          = OUT_STORED;
         r.slot             = free_idx[IDX_W-1:0];
         tries_q[free_idx]  = retry_limit_q;
         ident_q[free_idx]  = f.frag_ident;
         source_q[free_idx] = f.source_addr;
         offset_q[free_idx] = new_off[15:0];
         length_q[free_idx] = f.data_length;
      end else begin
         r.outcome = OUT_NOSLOT;
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         error_total++;
      end
   endtask

   // watch the three ports; results are compared before new items are queued
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (reset) begin
         for (int n = 0; n < ENTRIES; n++) begin
            tries_q[n]  = '0;
            ident_q[n]  = '0;
            source_q[n] = '0;
            offset_q[n] = '0;
            length_q[n] = '0;
         end
         retry_limit_q = RETRY_LIMIT_RESET;
         max_length_q  = MAX_LENGTH_RESET;
         pending_rsp_q.delete();
         error_total   = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RETRY_LIMIT: retry_limit_q = csr_wdata[TRIES_W-1:0];
               CSR_MAX_LENGTH:  max_length_q  = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp_q.size() == 0) begin
               $error("result item with none expected: outcome %0d slot %0d",
                      rsp_item.outcome, rsp_item.slot);
               error_total++;
            end else begin
               want = pending_rsp_q.pop_front();
               check_field("outcome", 16'(want.outcome), 16'(rsp_item.outcome));
               check_field("total_length", want.total_length, rsp_item.total_length);
               check_field("slot", 16'(want.slot), 16'(rsp_item.slot));
               check_field("partner_offset", want.partner_offset, rsp_item.partner_offset);
               check_field("partner_length", want.partner_length, rsp_item.partner_length);
            end
         end
         if (req_valid && !req_stall) begin
            pending_rsp_q.push_back(match_fragment(req_item));
         end
      end
      mismatch_count <= error_total;
      outstanding    <= pending_rsp_q.size();
   end

endmodule

FILE: bench/ip_fragment_pair_matcher_tb.sv
module ip_fragment_pair_matcher_tb;
   import ipfpm_pkg::*;

   localparam int KEYS        = 6;
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   req_item_type          req_item;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_item_type          rsp_item;
   int                    mismatch_count;
   int                    outstanding;
   int                    cycle_count = 0;

   // flows used by the random part, and first fragments already sent
   logic [15:0]  key_ident  [KEYS];
   logic [31:0]  key_source [KEYS];
   req_item_type first_frag_q[$];
   logic [15:0]  cur_max;

   ip_fragment_pair_matcher dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   ip_fragment_pair_matcher_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ip_fragment_pair_matcher_tb failed");
         $finish;
      end
   end

   // result side back-pressure: quiet stretches, short bursts, a few long holds
   initial begin
      int n;
      rsp_stall <= 1'b0;
      forever begin
         n = $urandom_range(0, 99);
         if (n < 25) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ((n < 90) ? $urandom_range(1, 3) : $urandom_range(15, 40))
               @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   end

   function automatic req_item_type frag(input logic [15:0] ident, input logic [31:0] src,
                                         input logic [12:0] units, input logic [15:0] len);
      req_item_type f;
      f.frag_ident   = ident;
      f.source_addr  = src;
      f.offset_units = units;
      f.data_length  = len;
      return f;
   endfunction

   // present one item after an idle gap and hold it until taken
   task automatic send_frag(input req_item_type f, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and let every outstanding result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // one register setting followed by random traffic
   task automatic run_phase(input logic [TRIES_W-1:0] retry, input logic [15:0] limit,
                            input int count);
      req_item_type f;
      req_item_type p;
      int           gap;
      int           roll;
      int           pick;
      int           k;
      int           room;
      int           span;
      int           cap_units;
      logic [16:0]  stop;
      wait_idle();
      // upper bits of the retry write are junk on purpose
      csr_wr_en <= 1'b1;
      csr_index <= CSR_RETRY_LIMIT;
      csr_wdata <= {12'($urandom), retry};
      @(posedge clock);
      csr_index <= CSR_MAX_LENGTH;
      csr_wdata <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_max = limit;
      // fresh flows; some share an ident but not the source
      for (k = 0; k < KEYS; k++) begin
         key_ident[k]  = 16'($urandom);
         key_source[k] = $urandom;
         if (k > 0 && $urandom_range(0, 3) == 0) key_ident[k] = key_ident[k-1];
      end
      first_frag_q.delete();
      cap_units = cur_max / 16;
      if (cap_units > 400) cap_units = 400;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         k    = $urandom_range(0, KEYS - 1);
         f.frag_ident   = key_ident[k];
         f.source_addr  = key_source[k];
         f.offset_units = ($urandom_range(0, 9) == 0) ? 13'($urandom)
                                                       : 13'($urandom_range(0, 300));
         f.data_length  = 16'(8 * $urandom_range(0, cap_units));
         if (pick >= 40 && pick < 90 && first_frag_q.size() > 0) begin
            // partner of an earlier first fragment
            p = first_frag_q[$urandom_range(0, first_frag_q.size() - 1)];
            f.frag_ident  = p.frag_ident;
            f.source_addr = p.source_addr;
            stop = {1'b0, p.offset_units, 3'b000} + {1'b0, p.data_length};
            room = (cur_max > p.data_length) ? cur_max - p.data_length : 0;
            if ($urandom_range(0, 1) == 1 && stop[2:0] == 3'b000 && stop[16:3] <= 8191) begin
               // starts where the stored one ends
               f.offset_units = stop[15:3];
               f.data_length  = 16'($urandom_range(0, room));
            end else if (p.offset_units != '0) begin
               // ends where the stored one starts
               span = room / 8;
               if (span < 1) span = 1;
               if (span > p.offset_units) span = p.offset_units;
               span = $urandom_range(1, span);
               f.offset_units = p.offset_units - 13'(span);
               f.data_length  = 16'(span * 8);
            end
            // broken partner: off by one unit or too long
            if (pick >= 75) begin
               case ($urandom_range(0, 2))
                  0: f.offset_units = f.offset_units + 13'd1;
                  1: f.offset_units = f.offset_units - 13'd1;
                  default: f.data_length = f.data_length + 16'($urandom_range(1, 64));
               endcase
            end
         end else if (pick >= 90) begin
            // noise over the whole field range
            f.frag_ident   = 16'($urandom);
            f.source_addr  = $urandom;
            f.offset_units = 13'($urandom);
            f.data_length  = 16'($urandom);
         end else begin
            first_frag_q.push_back(f);
            if (first_frag_q.size() > 8) void'(first_frag_q.pop_front());
         end
         roll = $urandom_range(0, 99);
         gap  = (roll < 70) ? 0 : (roll < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         send_frag(f, gap);
      end
   endtask

   initial begin
      reset     <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_item  <= '0;
      cur_max   = MAX_LENGTH_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset register values
      send_frag(frag(16'h0001, 32'h0a000001, 13'd0, 16'd1480), 0);
      // pair exactly at max_length
      send_frag(frag(16'h0001, 32'h0a000001, 13'd185, 16'd20), 1);
      send_frag(frag(16'h0002, 32'h0a000002, 13'd100, 16'd400), 0);
      // new fragment ends where the stored one starts
      send_frag(frag(16'h0002, 32'h0a000002, 13'd0, 16'd800), 0);
      // stored end passes 16 bits; must not wrap onto offset 8
      send_frag(frag(16'h0003, 32'h0a000003, 13'd8191, 16'd16), 2);
      send_frag(frag(16'h0003, 32'h0a000003, 13'd1, 16'd8), 0);
      // new end reaches 65536; must not wrap onto offset 0
      send_frag(frag(16'h0004, 32'h0a000004, 13'd0, 16'd16), 0);
      send_frag(frag(16'h0004, 32'h0a000004, 13'd8191, 16'd8), 0);
      // adjacent but one byte over max_length
      send_frag(frag(16'h0004, 32'h0a000004, 13'd2, 16'd1485), 0);
      // field extremes
      send_frag(frag(16'hffff, 32'hffffffff, 13'h1fff, 16'hffff), 3);
      send_frag(frag(16'h0000, 32'h00000000, 13'd0, 16'd0), 0);
      // table full: no slot
      send_frag(frag(16'h0005, 32'h0a000005, 13'd0, 16'd8), 0);
      // same ident, other source
      send_frag(frag(16'h0004, 32'h0b000004, 13'd2, 16'd8), 0);
      // all-ones and all-zeros keys match themselves
      send_frag(frag(16'hffff, 32'hffffffff, 13'd0, 16'd8), 0);
      send_frag(frag(16'h0000, 32'h00000000, 13'd0, 16'd0), 0);

      // register sweeps, extremes and a zero retry limit among them
      run_phase(4'd15, 16'd65535, 115);
      run_phase(4'd1, 16'd1500, 115);
      run_phase(4'd0, 16'd1500, 115);
      run_phase(4'd3, 16'd600, 115);
      run_phase(4'd15, 16'd0, 115);
      run_phase(4'd2, 16'd65535, 115);
      run_phase(4'd8, 16'd1500, 115);

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("ip_fragment_pair_matcher_tb passed");
      end else begin
         $display("ip_fragment_pair_matcher_tb failed");
      end
      $finish;
   end

endmodule
